>>> src/kl_pkg.sv
`default_nettype none

package kl_pkg;

    localparam int DEF_MAX_TEXT_LEN = 32;
    localparam int KW_COUNT = 6;
    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_B       = 8'h42;
    localparam logic [7:0] CH_D       = 8'h44;
    localparam logic [7:0] CH_E       = 8'h45;
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_H       = 8'h48;
    localparam logic [7:0] CH_I       = 8'h49;
    localparam logic [7:0] CH_L       = 8'h4C;
    localparam logic [7:0] CH_N       = 8'h4E;
    localparam logic [7:0] CH_O       = 8'h4F;
    localparam logic [7:0] CH_R       = 8'h52;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_T       = 8'h54;

    typedef enum logic [3:0] {
        KIND_IDENT,
        KIND_INT,
        KIND_BEGIN,
        KIND_END,
        KIND_FOR,
        KIND_IF,
        KIND_THEN,
        KIND_ELSE,
        KIND_PLUS,
        KIND_STAR,
        KIND_COMMA,
        KIND_LPAREN,
        KIND_RPAREN,
        KIND_COLON,
        KIND_ASSIGN,
        KIND_UNKNOWN
    } kind_t;

    typedef enum logic [2:0] {
        CLS_LETTER,
        CLS_DIGIT,
        CLS_COLON,
        CLS_EQUAL,
        CLS_SPACE,
        CLS_SYMBOL,
        CLS_OTHER
    } cls_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_COLON,
        MODE_HALT
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRONT,
        ST_START,
        ST_TAIL,
        ST_ID_LOAD,
        ST_ID_EMIT
    } state_t;

    typedef struct packed {
        logic  load_in;
        logic  add_letter;
        logic  add_digit;
        logic  clr_tok;
        logic  idx_clr;
        logic  idx_inc;
        logic  emit;
        kind_t emit_kind;
        logic  emit_last;
    } kl_cmd_t;

    typedef struct packed {
        cls_t  cls;
        kind_t sym_kind;
        logic  fin;
        logic  kw_hit;
        kind_t kw_kind;
        logic  id_last;
        logic  out_free;
    } kl_status_t;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t r;
        case (c) inside
            [CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]: r = CLS_LETTER;
            [CH_ZERO:CH_NINE]:                                r = CLS_DIGIT;
            CH_COLON:                                         r = CLS_COLON;
            CH_EQUAL:                                         r = CLS_EQUAL;
            CH_SPACE, CH_CR, CH_LF:                           r = CLS_SPACE;
            CH_PLUS, CH_STAR, CH_COMMA, CH_LPAREN, CH_RPAREN: r = CLS_SYMBOL;
            default:                                          r = CLS_OTHER;
        endcase
        return r;
    endfunction

    function automatic kind_t sym_kind_of(input logic [7:0] c);
        kind_t r;
        case (c)
            CH_PLUS:   r = KIND_PLUS;
            CH_STAR:   r = KIND_STAR;
            CH_COMMA:  r = KIND_COMMA;
            CH_LPAREN: r = KIND_LPAREN;
            CH_RPAREN: r = KIND_RPAREN;
            default:   r = KIND_UNKNOWN;
        endcase
        return r;
    endfunction

    // Keywords in order: BEGIN, END, FOR, IF, THEN, ELSE.
    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] r;
        case (k)
            3'd0:    r = 3'd5;
            3'd1:    r = 3'd3;
            3'd2:    r = 3'd3;
            3'd3:    r = 3'd2;
            3'd4:    r = 3'd4;
            3'd5:    r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
        logic [39:0] word;
        logic [7:0]  r;
        case (k)
            3'd0:    word = {CH_N, CH_I, CH_G, CH_E, CH_B};
            3'd1:    word = {8'h00, 8'h00, CH_D, CH_N, CH_E};
            3'd2:    word = {8'h00, 8'h00, CH_R, CH_O, CH_F};
            3'd3:    word = {8'h00, 8'h00, 8'h00, CH_F, CH_I};
            3'd4:    word = {8'h00, CH_N, CH_E, CH_H, CH_T};
            3'd5:    word = {8'h00, CH_E, CH_S, CH_L, CH_E};
            default: word = '0;
        endcase
        case (pos)
            3'd0:    r = word[7:0];
            3'd1:    r = word[15:8];
            3'd2:    r = word[23:16];
            3'd3:    r = word[31:24];
            3'd4:    r = word[39:32];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/kl_ram.sv
`default_nettype none

module kl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/kl_dpath.sv
`default_nettype none

module kl_dpath
    import kl_pkg::*;
#(
    parameter int MAX_TEXT_LEN = DEF_MAX_TEXT_LEN
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire logic       m_tready,
    output logic            m_tvalid,
    output logic [47:0]     m_tdata,
    output logic [3:0]      m_tuser,
    output logic            m_tlast,
    input  wire kl_cmd_t    cmd,
    output kl_status_t      status
);

    localparam int LEN_W = $clog2(MAX_TEXT_LEN + 1);
    localparam int IDX_W = $clog2(MAX_TEXT_LEN);

    logic [7:0]          char_reg;
    logic                fin_reg;
    logic [30:0]         acc_reg, acc_next;
    logic                ovf_reg, ovf_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [KW_COUNT-1:0] match_reg, match_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    logic                m_tvalid_reg, m_tvalid_next;
    kind_t               out_kind_reg;
    logic [30:0]         out_num_reg;
    logic [7:0]          out_char_reg;
    logic [4:0]          out_index_reg;
    logic                out_end_reg;
    logic                out_ovf_reg;
    logic                out_last_reg;

    logic [34:0]         acc_x10;
    logic [34:0]         digit_sum;
    logic                ram_we;
    logic [7:0]          ram_q;
    logic                kw_hit;
    kind_t               kw_kind;
    logic                id_last;
    logic [IDX_W+4:0]    idx_ext;

    assign acc_x10   = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
    assign digit_sum = acc_x10 + {31'b0, char_reg[3:0]};

    always_comb begin
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        len_next   = len_reg;
        match_next = match_reg;
        ram_we     = 1'b0;
        if (cmd.clr_tok) begin
            acc_next   = '0;
            ovf_next   = 1'b0;
            len_next   = '0;
            match_next = '1;
        end else if (cmd.add_digit) begin
            if (digit_sum > {4'b0000, NUM_MAX}) begin
                acc_next = NUM_MAX;
                ovf_next = 1'b1;
            end else begin
                acc_next = digit_sum[30:0];
            end
        end else if (cmd.add_letter) begin
            if (len_reg < LEN_W'(MAX_TEXT_LEN)) begin
                ram_we   = 1'b1;
                len_next = len_reg + LEN_W'(1);
                for (int k = 0; k < KW_COUNT; k++) begin
                    match_next[k] = match_reg[k]
                        && (len_reg < LEN_W'(kw_len(3'(k))))
                        && (kw_char(3'(k), len_reg[2:0]) == char_reg);
                end
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        kw_hit  = 1'b0;
        kw_kind = KIND_BEGIN;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (!kw_hit && match_reg[k] && !ovf_reg
                    && (len_reg == LEN_W'(kw_len(3'(k))))) begin
                kw_hit  = 1'b1;
                kw_kind = kind_t'(4'(int'(KIND_BEGIN) + k));
            end
        end
    end

    assign id_last = (LEN_W'(idx_reg) + LEN_W'(1)) == len_reg;
    assign idx_ext = {5'b00000, idx_reg};

    kl_ram #(
        .WIDTH(8),
        .DEPTH(MAX_TEXT_LEN)
    ) u_text_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (len_reg[IDX_W-1:0]),
        .wdata (char_reg),
        .raddr (idx_next),
        .rdata (ram_q)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            len_reg      <= '0;
            match_reg    <= '1;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            acc_reg      <= acc_next;
            ovf_reg      <= ovf_next;
            len_reg      <= len_next;
            match_reg    <= match_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            char_reg <= s_tdata;
            fin_reg  <= s_tlast;
        end
        if (cmd.emit) begin
            out_kind_reg  <= cmd.emit_kind;
            out_num_reg   <= (cmd.emit_kind == KIND_INT) ? acc_reg : '0;
            out_char_reg  <= (cmd.emit_kind == KIND_IDENT) ? ram_q : 8'h00;
            out_index_reg <= (cmd.emit_kind == KIND_IDENT) ? idx_ext[4:0] : 5'd0;
            out_end_reg   <= (cmd.emit_kind == KIND_IDENT) && id_last;
            out_ovf_reg   <= ((cmd.emit_kind == KIND_IDENT) || (cmd.emit_kind == KIND_INT))
                             && ovf_reg;
            out_last_reg  <= cmd.emit_last;
        end
    end

    assign status.cls      = classify(char_reg);
    assign status.sym_kind = sym_kind_of(char_reg);
    assign status.fin      = fin_reg;
    assign status.kw_hit   = kw_hit;
    assign status.kw_kind  = kw_kind;
    assign status.id_last  = id_last;
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_ovf_reg, out_end_reg, out_index_reg, out_char_reg,
                       out_num_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> src/kl_ctrl.sv
`default_nettype none

module kl_ctrl
    import kl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire kl_status_t status,
    output kl_cmd_t         cmd
);

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic   ret_reg, ret_next;
    logic   alnum;
    logic   more;

    assign alnum = (status.cls == CLS_LETTER) || (status.cls == CLS_DIGIT);

    // True when the current word will produce further results after a pending
    // token is flushed ahead of it.
    assign more = (status.cls == CLS_SYMBOL) || (status.cls == CLS_OTHER)
               || (status.cls == CLS_EQUAL)
               || (status.fin && (alnum || (status.cls == CLS_COLON)));

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_FRONT;
                end
            end
            ST_FRONT: begin
                unique case (mode_reg)
                    MODE_IDENT: begin
                        if (alnum) begin
                            state_next = status.fin ? ST_TAIL : ST_IDLE;
                        end else if (status.kw_hit) begin
                            if (status.out_free) begin
                                mode_next  = MODE_IDLE;
                                state_next = ST_START;
                            end
                        end else begin
                            ret_next   = 1'b1;
                            state_next = ST_ID_LOAD;
                        end
                    end
                    MODE_NUMBER: begin
                        if (status.cls == CLS_DIGIT) begin
                            state_next = status.fin ? ST_TAIL : ST_IDLE;
                        end else if (status.out_free) begin
                            mode_next  = MODE_IDLE;
                            state_next = ST_START;
                        end
                    end
                    MODE_COLON: begin
                        if (status.out_free) begin
                            mode_next  = MODE_IDLE;
                            state_next = (status.cls == CLS_EQUAL) ? ST_IDLE : ST_START;
                        end
                    end
                    MODE_IDLE: begin
                        state_next = ST_START;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_START: begin
                unique case (status.cls)
                    CLS_LETTER: begin
                        mode_next  = MODE_IDENT;
                        state_next = status.fin ? ST_TAIL : ST_IDLE;
                    end
                    CLS_DIGIT: begin
                        mode_next  = MODE_NUMBER;
                        state_next = status.fin ? ST_TAIL : ST_IDLE;
                    end
                    CLS_COLON: begin
                        mode_next  = MODE_COLON;
                        state_next = status.fin ? ST_TAIL : ST_IDLE;
                    end
                    CLS_SPACE: begin
                        state_next = ST_IDLE;
                    end
                    CLS_SYMBOL: begin
                        if (status.out_free) begin
                            state_next = ST_IDLE;
                        end
                    end
                    default: begin
                        if (status.out_free) begin
                            mode_next  = MODE_HALT;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_TAIL: begin
                unique case (mode_reg)
                    MODE_IDENT: begin
                        if (!status.kw_hit) begin
                            ret_next   = 1'b0;
                            state_next = ST_ID_LOAD;
                        end else if (status.out_free) begin
                            mode_next  = MODE_IDLE;
                            state_next = ST_IDLE;
                        end
                    end
                    MODE_NUMBER, MODE_COLON: begin
                        if (status.out_free) begin
                            mode_next  = MODE_IDLE;
                            state_next = ST_IDLE;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ID_LOAD: begin
                state_next = ST_ID_EMIT;
            end
            ST_ID_EMIT: begin
                if (status.out_free && status.id_last) begin
                    mode_next  = MODE_IDLE;
                    state_next = ret_reg ? ST_START : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd       = '0;
        s_tready  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_FRONT: begin
                unique case (mode_reg)
                    MODE_IDENT: begin
                        if (alnum) begin
                            cmd.add_letter = 1'b1;
                        end else if (status.kw_hit && status.out_free) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = status.kw_kind;
                            cmd.emit_last = !more;
                            cmd.clr_tok   = 1'b1;
                        end
                    end
                    MODE_NUMBER: begin
                        if (status.cls == CLS_DIGIT) begin
                            cmd.add_digit = 1'b1;
                        end else if (status.out_free) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_INT;
                            cmd.emit_last = !more;
                            cmd.clr_tok   = 1'b1;
                        end
                    end
                    MODE_COLON: begin
                        if (status.out_free) begin
                            cmd.emit = 1'b1;
                            if (status.cls == CLS_EQUAL) begin
                                cmd.emit_kind = KIND_ASSIGN;
                                cmd.emit_last = 1'b1;
                            end else begin
                                cmd.emit_kind = KIND_COLON;
                                cmd.emit_last = !more;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_START: begin
                unique case (status.cls)
                    CLS_LETTER: begin
                        cmd.add_letter = 1'b1;
                    end
                    CLS_DIGIT: begin
                        cmd.add_digit = 1'b1;
                    end
                    CLS_COLON, CLS_SPACE: begin
                    end
                    CLS_SYMBOL: begin
                        cmd.emit      = status.out_free;
                        cmd.emit_kind = status.sym_kind;
                        cmd.emit_last = 1'b1;
                    end
                    default: begin
                        cmd.emit      = status.out_free;
                        cmd.emit_kind = KIND_UNKNOWN;
                        cmd.emit_last = 1'b1;
                    end
                endcase
            end
            ST_TAIL: begin
                unique case (mode_reg)
                    MODE_IDENT: begin
                        if (status.kw_hit && status.out_free) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = status.kw_kind;
                            cmd.emit_last = 1'b1;
                            cmd.clr_tok   = 1'b1;
                        end
                    end
                    MODE_NUMBER: begin
                        if (status.out_free) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_INT;
                            cmd.emit_last = 1'b1;
                            cmd.clr_tok   = 1'b1;
                        end
                    end
                    MODE_COLON: begin
                        if (status.out_free) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_COLON;
                            cmd.emit_last = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_ID_LOAD: begin
                cmd.idx_clr = 1'b1;
            end
            ST_ID_EMIT: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_IDENT;
                    cmd.emit_last = status.id_last && (!ret_reg || !more);
                    cmd.idx_inc   = !status.id_last;
                    cmd.clr_tok   = status.id_last;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_IDLE;
            ret_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            ret_reg   <= ret_next;
        end
    end

`ifndef SYNTHESIS
    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("Result issued while the output register was occupied.");

    a_halt_is_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_HALT) |-> !cmd.emit)
        else $error("Result issued after an unknown character.");

    a_emit_in_ident: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ID_EMIT) |-> (mode_reg == MODE_IDENT))
        else $error("Identifier readout outside identifier mode.");

    a_start_when_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_START) |-> (mode_reg == MODE_IDLE))
        else $error("New token started while another one was pending.");
`endif

endmodule

`default_nettype wire

>>> src/keyword_lexer.sv
// Character-stream tokenizer: one ASCII byte per input word (s_tlast marks the
// final byte), one token per output word, with identifiers that are not keywords
// delivered one character per word and m_tlast set on the last word caused by each
// input byte. A byte that extends a pending identifier or integer passes the front
// state; one that starts a token or is a symbol also passes the start state, and a
// final flag that leaves a token pending adds the tail state. A plain identifier is
// flushed by a buffer read and then one result per character, as its characters come
// out of the single read port of the text buffer through the single output register.
// Any byte that is not a letter, digit, symbol, colon, space, CR, LF or an equals sign
// after a colon yields an Unknown word and stops all output until reset.
`default_nettype none

module keyword_lexer
    import kl_pkg::*;
#(
    parameter int MAX_TEXT_LEN = DEF_MAX_TEXT_LEN
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_char
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // number, text_char, text_index, text_end, overflow
    output logic      [3:0]  m_tuser,   // kind
    output logic             m_tlast
);

    kl_cmd_t    cmd;
    kl_status_t status;

    kl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kl_dpath #(
        .MAX_TEXT_LEN(MAX_TEXT_LEN)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kl_pkg::*;

    localparam int TEXT_MAX = DEF_MAX_TEXT_LEN;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_MAX = 10;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_ALL_ONES = 8'hFF;

    typedef struct packed {
        kind_t       kind;
        logic [30:0] number;
        logic [7:0]  text_char;
        logic [4:0]  text_index;
        logic        text_end;
        logic        overflow;
        logic        last;
    } token_word_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;

    mode_t       lex_mode;
    logic [7:0]  id_text [TEXT_MAX];
    int          id_len;
    logic [30:0] num_val;
    logic        tok_ovf;
    token_word_t step_words[$];
    token_word_t expected_words[$];

    string keyword_words [6] = '{"BEGIN", "END", "FOR", "IF", "THEN", "ELSE"};
    logic [7:0] symbol_chars [5] = '{CH_PLUS, CH_STAR, CH_COMMA, CH_LPAREN, CH_RPAREN};
    logic [7:0] blank_chars [3] = '{CH_SPACE, CH_CR, CH_LF};
    logic [7:0] noise_chars [10] = '{CH_PLUS, CH_STAR, CH_COMMA, CH_LPAREN, CH_RPAREN,
                                     CH_COLON, CH_EQUAL, CH_SPACE, CH_CR, CH_LF};

    keyword_lexer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void add_word(kind_t k, logic [30:0] n, logic [7:0] ch,
                                     logic [4:0] ix, logic e, logic o);
        token_word_t w;
        w.kind = k;
        w.number = n;
        w.text_char = ch;
        w.text_index = ix;
        w.text_end = e;
        w.overflow = o;
        w.last = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void add_symbol(kind_t k);
        add_word(k, '0, '0, '0, 1'b0, 1'b0);
    endfunction

    function automatic void drop_token();
        lex_mode = MODE_IDLE;
        id_len = 0;
        num_val = '0;
        tok_ovf = 1'b0;
    endfunction

    function automatic int keyword_index();
        bit same;
        for (int k = 0; k < 6; k++) begin
            if (keyword_words[k].len() == id_len) begin
                same = 1'b1;
                for (int i = 0; i < id_len; i++) begin
                    if (keyword_words[k][i] != id_text[i]) same = 1'b0;
                end
                if (same) return k;
            end
        end
        return -1;
    endfunction

    function automatic void flush_token();
        int k;
        if (lex_mode == MODE_IDENT) begin
            k = tok_ovf ? -1 : keyword_index();
            if (k >= 0) begin
                add_symbol(kind_t'(KIND_BEGIN + k));
            end else begin
                for (int i = 0; i < id_len; i++) begin
                    add_word(KIND_IDENT, '0, id_text[i], 5'(i), i == id_len - 1, tok_ovf);
                end
            end
        end else if (lex_mode == MODE_NUMBER) begin
            add_word(KIND_INT, num_val, '0, '0, 1'b0, tok_ovf);
        end else if (lex_mode == MODE_COLON) begin
            add_symbol(KIND_COLON);
        end
        drop_token();
    endfunction

    function automatic void push_digit(logic [7:0] c);
        logic [34:0] v;
        logic [7:0]  d;
        d = c - CH_ZERO;
        v = 35'(num_val) * 35'd10 + 35'(d);
        if (v > 35'(NUM_MAX)) begin
            v = 35'(NUM_MAX);
            tok_ovf = 1'b1;
        end
        num_val = v[30:0];
    endfunction

    function automatic void push_letter(logic [7:0] c);
        if (id_len < TEXT_MAX) begin
            id_text[id_len] = c;
            id_len++;
        end else begin
            tok_ovf = 1'b1;
        end
    endfunction

    function automatic void start_token(logic [7:0] c);
        drop_token();
        if (is_alpha(c)) begin
            lex_mode = MODE_IDENT;
            push_letter(c);
        end else if (is_num(c)) begin
            lex_mode = MODE_NUMBER;
            push_digit(c);
        end else begin
            case (c)
                CH_PLUS:   add_symbol(KIND_PLUS);
                CH_STAR:   add_symbol(KIND_STAR);
                CH_COMMA:  add_symbol(KIND_COMMA);
                CH_LPAREN: add_symbol(KIND_LPAREN);
                CH_RPAREN: add_symbol(KIND_RPAREN);
                CH_COLON:  lex_mode = MODE_COLON;
                CH_SPACE, CH_CR, CH_LF: ;
                default: begin
                    add_symbol(KIND_UNKNOWN);
                    lex_mode = MODE_HALT;
                end
            endcase
        end
    endfunction

    function automatic void predict_tokens(logic [7:0] c, logic fin);
        bit          taken;
        token_word_t w;
        taken = 1'b0;
        step_words.delete();
        if (lex_mode == MODE_HALT) return;
        case (lex_mode)
            MODE_IDENT: begin
                if (is_alpha(c) || is_num(c)) begin
                    push_letter(c);
                    taken = 1'b1;
                end else begin
                    flush_token();
                end
            end
            MODE_NUMBER: begin
                if (is_num(c)) begin
                    push_digit(c);
                    taken = 1'b1;
                end else begin
                    flush_token();
                end
            end
            MODE_COLON: begin
                if (c == CH_EQUAL) begin
                    add_symbol(KIND_ASSIGN);
                    drop_token();
                    taken = 1'b1;
                end else begin
                    flush_token();
                end
            end
            default: drop_token();
        endcase
        if (!taken) start_token(c);
        if (fin && lex_mode != MODE_HALT) flush_token();
        for (int i = 0; i < step_words.size(); i++) begin
            w = step_words[i];
            w.last = (i == step_words.size() - 1);
            expected_words.push_back(w);
        end
    endfunction

    function automatic string word_text(token_word_t w);
        return $sformatf("kind %0d number %0d char %02h index %0d end %0b ovf %0b last %0b",
                         w.kind, w.number, w.text_char, w.text_index, w.text_end,
                         w.overflow, w.last);
    endfunction

    function automatic void report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) $display("%0t: %s", $time, msg);
    endfunction

    function automatic void check_token_word();
        token_word_t got;
        token_word_t want;
        got.kind = kind_t'(m_tuser);
        got.number = m_tdata[30:0];
        got.text_char = m_tdata[38:31];
        got.text_index = m_tdata[43:39];
        got.text_end = m_tdata[44];
        got.overflow = m_tdata[45];
        got.last = m_tlast;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word: %s", word_text(got)));
        end else begin
            want = expected_words.pop_front();
            if (got.kind !== want.kind || got.number !== want.number ||
                got.text_char !== want.text_char || got.text_index !== want.text_index ||
                got.text_end !== want.text_end || got.overflow !== want.overflow ||
                got.last !== want.last) begin
                report_mismatch($sformatf("expected %s, got %s",
                                          word_text(want), word_text(got)));
            end
        end
    endfunction

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_token_word();
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic send_char(logic [7:0] c, logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        predict_tokens(c, fin);
    endtask

    task automatic send_text(string s, logic fin_last);
        for (int i = 0; i < s.len(); i++) send_char(s[i], fin_last && i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] off;
        off = 8'($urandom_range(25));
        return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + off;
    endfunction

    function automatic logic [7:0] rand_digit();
        logic [7:0] off;
        off = 8'($urandom_range(9));
        return CH_ZERO + off;
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(2) == 0) ? rand_digit() : rand_letter();
    endfunction

    function automatic logic rand_fin();
        return $urandom_range(99) < 3;
    endfunction

    // A lone equals sign would stop the block for good, so it only goes out after a colon.
    task automatic send_rand(logic [7:0] c);
        if (c == CH_EQUAL && lex_mode != MODE_COLON) c = CH_SPACE;
        send_char(c, rand_fin());
    endtask

    task automatic send_rand_text(string s);
        for (int i = 0; i < s.len(); i++) send_rand(s[i]);
    endtask

    task automatic send_random_token();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 15) begin
            send_rand_text(keyword_words[$urandom_range(5)]);
        end else if (pick < 38) begin
            n = (pick < 34) ? $urandom_range(1, 8) : $urandom_range(30, 40);
            send_rand(rand_letter());
            for (int i = 1; i < n; i++) send_rand(rand_alnum());
        end else if (pick < 56) begin
            n = (pick < 50) ? $urandom_range(1, 6) : $urandom_range(9, 13);
            for (int i = 0; i < n; i++) send_rand(rand_digit());
        end else if (pick < 59) begin
            if (pick == 56) send_rand_text("2147483647");
            else send_rand_text("2147483648");
        end else if (pick < 74) begin
            send_rand(symbol_chars[$urandom_range(4)]);
        end else if (pick < 82) begin
            send_rand_text(":=");
        end else if (pick < 86) begin
            send_rand(CH_COLON);
        end else begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(1)) send_rand(rand_alnum());
                else send_rand(noise_chars[$urandom_range(9)]);
            end
        end
        if ($urandom_range(99) < 55) send_rand(blank_chars[$urandom_range(2)]);
    endtask

    task automatic test_directed_tokens();
        set_idling(0, 0);
        send_text("ELSE:=(zZ09)*,+:7 ", 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(CH_LF, 1'b0);
        send_text("IF", 1'b1);
        send_text(":", 1'b1);
    endtask

    task automatic test_random_stream(int count, int send_pct, int recv_pct);
        int stop_at;
        stop_at = items_sent + count;
        set_idling(send_pct, recv_pct);
        while (items_sent < stop_at) send_random_token();
    endtask

    task automatic test_halt_on_unknown();
        logic [7:0] bad_chars [4];
        logic [7:0] high_char;
        high_char = 8'h80 | 8'($urandom_range(127));
        bad_chars = '{CH_EQUAL, CH_TAB, high_char, CH_HASH};
        set_idling(21, 21);
        send_text("ab", 1'b0);
        send_char(bad_chars[$urandom_range(3)], 1'b0);
        send_char(CH_ALL_ONES, 1'b1);
        repeat (20) send_char(8'($urandom_range(255)), rand_fin());
    endtask

    initial begin
        drop_token();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_tokens();
        test_random_stream(90, 0, 0);
        test_random_stream(90, 60, 0);
        test_random_stream(90, 0, 60);
        test_random_stream(90, 21, 21);
        test_halt_on_unknown();

        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
src/kl_pkg.sv
src/kl_ram.sv
src/kl_dpath.sv
src/kl_ctrl.sv
src/keyword_lexer.sv
dv/tb_top.sv
